>>> rtl/flvavc_pkg.sv
// Shared constants and the per-tag summary record for the FLV AVC video tag parser.
package flvavc_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_LSIZE  = 2'd2;

    localparam logic [3:0] CODEC_AVC   = 4'd7;
    localparam logic [7:0] PKT_SEQ_HDR = 8'd0;
    localparam logic [7:0] PKT_NALU    = 8'd1;

    localparam logic [23:0] POS_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic        hdr_done;
        logic        seq_done;
        logic [1:0]  err;
        logic [63:0] held;
        logic [7:0]  level;
        logic [2:0]  fsize;
        logic [23:0] plen;
        logic [23:0] ucnt;
    } tag_rec_t;

endpackage

>>> rtl/flv_avc_video_tag_parser.sv
// Top level of the FLV AVC video tag parser: parser, record queue and result stage.
// Throughput: one payload byte per cycle; s_ready falls only while the queue is full behind a waiting result.
// Result path: at the last byte's transfer the tag record is written into the record queue,
//   and from there into the output register once the result stage is free to take it.
// Reset: aresetn is synchronous and active low; it clears parse state, queue and output
//   valid, and sets nal_length_size to 4. No clearing pass; items are taken right after reset.
module flv_avc_video_tag_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [23:0] s_payload_length,
    input  logic        s_last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_nal_length_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_codec_id,
    output logic [3:0]  m_frame_type,
    output logic [7:0]  m_avc_packet_type,
    output logic [23:0] m_composition_time,
    output logic [7:0]  m_config_version,
    output logic [7:0]  m_profile_indication,
    output logic [7:0]  m_profile_compat,
    output logic [7:0]  m_level_indication,
    output logic [2:0]  m_found_length_size,
    output logic [23:0] m_parameter_sets_length,
    output logic [23:0] m_nalu_count
);
    import flvavc_pkg::*;

    logic     push_valid;
    logic     push_ready;
    tag_rec_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    tag_rec_t pop_data;

    flvavc_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_payload_length    (s_payload_length),
        .s_last_byte         (s_last_byte),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_nal_length_size (cfg_nal_length_size),
        .rec_valid           (push_valid),
        .rec_ready           (push_ready),
        .rec_data            (push_data)
    );

    flvavc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    flvavc_back u_back (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .rec_valid               (pop_valid),
        .rec_ready               (pop_ready),
        .rec_data                (pop_data),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_status                (m_status),
        .m_codec_id              (m_codec_id),
        .m_frame_type            (m_frame_type),
        .m_avc_packet_type       (m_avc_packet_type),
        .m_composition_time      (m_composition_time),
        .m_config_version        (m_config_version),
        .m_profile_indication    (m_profile_indication),
        .m_profile_compat        (m_profile_compat),
        .m_level_indication      (m_level_indication),
        .m_found_length_size     (m_found_length_size),
        .m_parameter_sets_length (m_parameter_sets_length),
        .m_nalu_count            (m_nalu_count)
    );

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_FORMAT || m_status == ST_LSIZE))
        else $error("result status out of range");

    a_lsize_no_units: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_LSIZE) |->
            (m_codec_id == CODEC_AVC && m_avc_packet_type == PKT_NALU && m_nalu_count == 24'd0))
        else $error("length size error with units counted");

    a_non_avc_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_codec_id != CODEC_AVC) |->
            (m_status == ST_OK && m_avc_packet_type == 8'd0 && m_nalu_count == 24'd0
             && m_parameter_sets_length == 24'd0))
        else $error("non-AVC tag carries AVC fields");

    a_queue_push_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("tag record pushed into full queue");

endmodule

>>> rtl/flvavc_front.sv
// Byte parser: walks the tag header, sequence header and NALU length prefixes.
module flvavc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic [23:0]         s_payload_length,
    input  logic                s_last_byte,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_nal_length_size,
    output logic                rec_valid,
    input  logic                rec_ready,
    output flvavc_pkg::tag_rec_t rec_data
);
    import flvavc_pkg::*;

    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_AVCHDR = 6'b000010,
        PH_SEQ    = 6'b000100,
        PH_SCAN   = 6'b001000,
        PH_PREF   = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_upd, phase_next;
    logic [2:0]  nls_reg;
    logic [23:0] pos_reg, pos_next;
    logic [63:0] held_reg, held_upd, held_next;
    logic [7:0]  level_reg, level_upd, level_next;
    logic [2:0]  fsize_reg, fsize_upd, fsize_next;
    logic [24:0] uoff_reg, uoff_upd, uoff_next;
    logic [31:0] acc_reg, acc_upd, acc_next;
    logic [1:0]  skip_reg, skip_upd, skip_next;
    logic [23:0] ucnt_reg, ucnt_upd, ucnt_next;
    logic [1:0]  err_reg, err_upd, err_next;
    logic        lsz4_reg, lsz4_upd, lsz4_next;

    logic        accept;
    logic [25:0] uoff_plus5;
    logic [25:0] uoff_plus9;
    logic [31:0] acc_shift;
    logic        unit_too_big;
    logic [24:0] uoff_adv;
    logic [1:0]  skip_dec;

    assign s_ready   = rec_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;

    assign uoff_plus5   = {1'b0, uoff_reg} + 26'd5;
    assign uoff_plus9   = {1'b0, uoff_reg} + 26'd9;
    assign acc_shift    = {acc_reg[23:0], s_data_byte};
    assign unit_too_big = ({1'b0, acc_shift} + 33'd5) >= {9'd0, s_payload_length};
    assign uoff_adv     = uoff_reg + {1'b0, acc_shift[23:0]} + (lsz4_reg ? 25'd4 : 25'd3);
    assign skip_dec     = (skip_reg != 2'd0) ? skip_reg - 2'd1 : 2'd0;

    always_comb begin
        phase_upd = phase_reg;
        held_upd  = held_reg;
        level_upd = level_reg;
        fsize_upd = fsize_reg;
        uoff_upd  = uoff_reg;
        acc_upd   = acc_reg;
        skip_upd  = skip_reg;
        ucnt_upd  = ucnt_reg;
        err_upd   = err_reg;
        lsz4_upd  = lsz4_reg;
        unique case (phase_reg)
            PH_FIRST: begin
                held_upd  = {56'd0, s_data_byte};
                phase_upd = (s_data_byte[3:0] == CODEC_AVC) ? PH_AVCHDR : PH_DONE;
            end
            PH_AVCHDR: begin
                case (pos_reg)
                    24'd1:   held_upd[15:8]  = s_data_byte;
                    24'd2:   held_upd[39:32] = s_data_byte;
                    24'd3:   held_upd[31:24] = s_data_byte;
                    24'd4:   held_upd[23:16] = s_data_byte;
                    default: ;
                endcase
                if (pos_reg >= 24'd4) begin
                    if (held_reg[15:8] == PKT_SEQ_HDR) begin
                        phase_upd = PH_SEQ;
                    end else if (held_reg[15:8] == PKT_NALU) begin
                        if (nls_reg == 3'd3) begin
                            phase_upd = PH_SCAN;
                            lsz4_upd  = 1'b0;
                        end else if (nls_reg == 3'd4) begin
                            phase_upd = PH_SCAN;
                            lsz4_upd  = 1'b1;
                        end else begin
                            err_upd   = ST_LSIZE;
                            phase_upd = PH_DONE;
                        end
                    end else begin
                        phase_upd = PH_DONE;
                    end
                end
            end
            PH_SEQ: begin
                case (pos_reg)
                    24'd5:   held_upd[47:40] = s_data_byte;
                    24'd6:   held_upd[55:48] = s_data_byte;
                    24'd7:   held_upd[63:56] = s_data_byte;
                    24'd8:   level_upd       = s_data_byte;
                    default: ;
                endcase
                if (pos_reg >= 24'd9) begin
                    fsize_upd = {1'b0, s_data_byte[1:0]} + 3'd1;
                    if (!s_data_byte[1]) begin
                        err_upd = ST_FORMAT;
                    end
                    phase_upd = PH_DONE;
                end
            end
            PH_SCAN: begin
                if ({2'b00, pos_reg} == uoff_plus5) begin
                    if (uoff_plus9 < {2'b00, s_payload_length}) begin
                        acc_upd   = {24'd0, s_data_byte};
                        skip_upd  = lsz4_reg ? 2'd3 : 2'd2;
                        phase_upd = PH_PREF;
                    end else begin
                        phase_upd = PH_DONE;
                    end
                end
            end
            PH_PREF: begin
                acc_upd  = acc_shift;
                skip_upd = skip_dec;
                if (skip_dec == 2'd0) begin
                    if (unit_too_big) begin
                        err_upd   = ST_FORMAT;
                        phase_upd = PH_DONE;
                    end else begin
                        ucnt_upd  = ucnt_reg + 24'd1;
                        uoff_upd  = uoff_adv;
                        phase_upd = PH_SCAN;
                    end
                end
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        level_next = level_reg;
        fsize_next = fsize_reg;
        uoff_next  = uoff_reg;
        acc_next   = acc_reg;
        skip_next  = skip_reg;
        ucnt_next  = ucnt_reg;
        err_next   = err_reg;
        lsz4_next  = lsz4_reg;
        if (accept) begin
            if (s_last_byte) begin
                phase_next = PH_FIRST;
                pos_next   = 24'd0;
                held_next  = 64'd0;
                level_next = 8'd0;
                fsize_next = 3'd0;
                uoff_next  = 25'd0;
                acc_next   = 32'd0;
                skip_next  = 2'd0;
                ucnt_next  = 24'd0;
                err_next   = ST_OK;
                lsz4_next  = 1'b0;
            end else begin
                phase_next = phase_upd;
                pos_next   = (pos_reg != POS_MAX) ? pos_reg + 24'd1 : pos_reg;
                held_next  = held_upd;
                level_next = level_upd;
                fsize_next = fsize_upd;
                uoff_next  = uoff_upd;
                acc_next   = acc_upd;
                skip_next  = skip_upd;
                ucnt_next  = ucnt_upd;
                err_next   = err_upd;
                lsz4_next  = lsz4_upd;
            end
        end
    end

    assign rec_valid         = accept & s_last_byte;
    assign rec_data.hdr_done = pos_reg >= 24'd4;
    assign rec_data.seq_done = pos_reg >= 24'd9;
    assign rec_data.err      = err_upd;
    assign rec_data.held     = held_upd;
    assign rec_data.level    = level_upd;
    assign rec_data.fsize    = fsize_upd;
    assign rec_data.plen     = s_payload_length;
    assign rec_data.ucnt     = ucnt_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            nls_reg   <= 3'd4;
            pos_reg   <= 24'd0;
            held_reg  <= 64'd0;
            level_reg <= 8'd0;
            fsize_reg <= 3'd0;
            uoff_reg  <= 25'd0;
            acc_reg   <= 32'd0;
            skip_reg  <= 2'd0;
            ucnt_reg  <= 24'd0;
            err_reg   <= ST_OK;
            lsz4_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                nls_reg <= cfg_nal_length_size;
            end
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            level_reg <= level_next;
            fsize_reg <= fsize_next;
            uoff_reg  <= uoff_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
            ucnt_reg  <= ucnt_next;
            err_reg   <= err_next;
            lsz4_reg  <= lsz4_next;
        end
    end

endmodule

>>> rtl/flvavc_fifo.sv
// Two-entry queue of tag summary records between parser and result stage.
module flvavc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  flvavc_pkg::tag_rec_t push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output flvavc_pkg::tag_rec_t pop_data
);
    import flvavc_pkg::*;

    tag_rec_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/flvavc_back.sv
// Result stage: resolves status and output fields of a tag and holds them for transfer.
module flvavc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    output logic                 rec_ready,
    input  flvavc_pkg::tag_rec_t rec_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [3:0]           m_codec_id,
    output logic [3:0]           m_frame_type,
    output logic [7:0]           m_avc_packet_type,
    output logic [23:0]          m_composition_time,
    output logic [7:0]           m_config_version,
    output logic [7:0]           m_profile_indication,
    output logic [7:0]           m_profile_compat,
    output logic [7:0]           m_level_indication,
    output logic [2:0]           m_found_length_size,
    output logic [23:0]          m_parameter_sets_length,
    output logic [23:0]          m_nalu_count
);
    import flvavc_pkg::*;

    logic        valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  codec_reg;
    logic [3:0]  frame_reg;
    logic [7:0]  ptype_reg, ptype_next;
    logic [23:0] ctime_reg, ctime_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  profile_reg, profile_next;
    logic [7:0]  compat_reg, compat_next;
    logic [7:0]  level_reg, level_next;
    logic [2:0]  fsize_reg, fsize_next;
    logic [23:0] psl_reg, psl_next;
    logic [23:0] nalu_reg, nalu_next;

    logic        load;
    logic [7:0]  ptype;
    logic [23:0] spare5;
    logic [23:0] spare10;

    assign rec_ready = !valid_reg || m_ready;
    assign load      = rec_valid && rec_ready;
    assign ptype     = rec_data.held[15:8];
    assign spare5    = (rec_data.plen > 24'd5)  ? rec_data.plen - 24'd5  : 24'd0;
    assign spare10   = (rec_data.plen > 24'd10) ? rec_data.plen - 24'd10 : 24'd0;

    always_comb begin
        status_next  = rec_data.err;
        ptype_next   = 8'd0;
        ctime_next   = 24'd0;
        version_next = 8'd0;
        profile_next = 8'd0;
        compat_next  = 8'd0;
        level_next   = 8'd0;
        fsize_next   = 3'd0;
        psl_next     = 24'd0;
        nalu_next    = 24'd0;
        if (rec_data.held[3:0] == CODEC_AVC) begin
            if (!rec_data.hdr_done && status_next == ST_OK) begin
                status_next = ST_FORMAT;
            end
            ptype_next = ptype;
            ctime_next = rec_data.held[39:16];
            if (rec_data.hdr_done && ptype == PKT_SEQ_HDR) begin
                if (!rec_data.seq_done && status_next == ST_OK) begin
                    status_next = ST_FORMAT;
                end
                version_next = rec_data.held[47:40];
                profile_next = rec_data.held[55:48];
                compat_next  = rec_data.held[63:56];
                level_next   = rec_data.level;
                fsize_next   = rec_data.fsize;
                psl_next     = (status_next == ST_OK) ? spare10 : 24'd0;
            end else if (rec_data.hdr_done && ptype == PKT_NALU) begin
                psl_next  = spare5;
                nalu_next = rec_data.ucnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg  <= status_next;
            codec_reg   <= rec_data.held[3:0];
            frame_reg   <= rec_data.held[7:4];
            ptype_reg   <= ptype_next;
            ctime_reg   <= ctime_next;
            version_reg <= version_next;
            profile_reg <= profile_next;
            compat_reg  <= compat_next;
            level_reg   <= level_next;
            fsize_reg   <= fsize_next;
            psl_reg     <= psl_next;
            nalu_reg    <= nalu_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_ready) begin
            valid_reg <= rec_valid;
        end
    end

    assign m_valid                 = valid_reg;
    assign m_status                = status_reg;
    assign m_codec_id              = codec_reg;
    assign m_frame_type            = frame_reg;
    assign m_avc_packet_type       = ptype_reg;
    assign m_composition_time      = ctime_reg;
    assign m_config_version        = version_reg;
    assign m_profile_indication    = profile_reg;
    assign m_profile_compat        = compat_reg;
    assign m_level_indication      = level_reg;
    assign m_found_length_size     = fsize_reg;
    assign m_parameter_sets_length = psl_reg;
    assign m_nalu_count            = nalu_reg;

endmodule
